/* sv/sts_pkg.sv */
// Shared types and constants for the scope trace smoother.
package sts_pkg;

  // Fixed field widths of the item and result channels
  localparam int CH_FW    = 5;
  localparam int COL_FW   = 5;
  localparam int SAMPLE_W = 8;
  localparam int ROW_FW   = 6;
  localparam int COLOUR_W = 2;
  localparam int WEIGHT_W = 9;

  // Four samples per column, summed into a two-bit wider word
  localparam int N_SAMPLES = 4;
  localparam int SUM_W     = SAMPLE_W + 2;

  // Serial multiplier operands: signed difference of two samples times 9-bit weight
  localparam int MCAND_W = SAMPLE_W + 2;
  localparam int PROD_W  = MCAND_W + WEIGHT_W;

  // Blend is out of 256, row scale is out of 128
  localparam int BLEND_SHIFT = 8;
  localparam int ROW_SHIFT   = 7;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd96;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [COLOUR_W-1:0] {
    COLOUR_UNUSED = 2'd0,
    COLOUR_NORMAL = 2'd1,
    COLOUR_MUTED  = 2'd2,
    COLOUR_SOLO   = 2'd3
  } colour_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_BLEND,
    ST_SCALE,
    ST_ROW
  } state_t;

endpackage

/* sv/sts_in_if.sv */
// Item channel: one channel column with its four samples.
interface sts_in_if import sts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_FW-1:0]    channel;
  logic [COL_FW-1:0]   column;
  logic                active;
  logic                muted;
  logic                soloed;
  sample_t             sample_a;
  sample_t             sample_b;
  sample_t             sample_c;
  sample_t             sample_d;

  modport source (
    output valid, channel, column, active, muted, soloed,
           sample_a, sample_b, sample_c, sample_d,
    input  ready
  );

  modport sink (
    input  valid, channel, column, active, muted, soloed,
           sample_a, sample_b, sample_c, sample_d,
    output ready
  );
endinterface

/* sv/sts_out_if.sv */
// Result channel: one vertical span to draw.
interface sts_out_if import sts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_FW-1:0]    out_channel;
  logic [COL_FW-1:0]   out_column;
  logic [ROW_FW-1:0]   span_top;
  logic [ROW_FW-1:0]   span_bottom;
  logic [COLOUR_W-1:0] colour;

  modport source (
    output valid, out_channel, out_column, span_top, span_bottom, colour,
    input  ready
  );

  modport sink (
    input  valid, out_channel, out_column, span_top, span_bottom, colour,
    output ready
  );
endinterface

/* sv/sts_sample_acc.sv */
// Sample shift line: sums the four samples one per cycle.
module sts_sample_acc import sts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  sample_t                 samples [N_SAMPLES],
  output logic                    done,
  output logic signed [SUM_W-1:0] sum
);

  localparam int CNT_W = $clog2(N_SAMPLES + 1);

  sample_t          sh [N_SAMPLES];
  logic [CNT_W-1:0] cnt;

  // shift samples toward slot 0, add slot 0 each step
  always_ff @(posedge clk) begin
    if (load) begin
      sh  <= samples;
      sum <= '0;
    end else if (cnt != '0) begin
      sum <= sum + SUM_W'(sh[0]);
      for (int i = 0; i < N_SAMPLES - 1; i++) begin
        sh[i] <= sh[i+1];
      end
    end
  end

  // step count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_W'(N_SAMPLES);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign done = (cnt == '0);

endmodule

/* sv/sts_serial_mul.sv */
// Digit-serial signed by unsigned multiplier, two multiplier bits per cycle.
module sts_serial_mul import sts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic [WEIGHT_W-1:0]       mplier,
  output logic                      done,
  output logic signed [PROD_W-1:0]  product
);

  localparam int DIG_W = 2;
  localparam int N_DIG = (WEIGHT_W + DIG_W - 1) / DIG_W;
  localparam int CNT_W = $clog2(N_DIG + 1);

  logic signed [PROD_W-1:0] mc_sh;
  logic [WEIGHT_W-1:0]      ml_sh;
  logic [CNT_W-1:0]         cnt;
  logic                     busy;
  logic signed [PROD_W-1:0] pp;

  // partial product of the current two-bit digit
  always_comb begin
    pp = '0;
    if (ml_sh[0]) begin
      pp = pp + mc_sh;
    end
    if (ml_sh[1]) begin
      pp = pp + (mc_sh <<< 1);
    end
  end

  // multiplicand shifts up, multiplier shifts down, one digit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mc_sh   <= PROD_W'(mcand);
      ml_sh   <= mplier;
      product <= '0;
    end else if (cnt != '0) begin
      product <= product + pp;
      mc_sh   <= mc_sh <<< DIG_W;
      ml_sh   <= ml_sh >> DIG_W;
    end
  end

  // digit count and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(N_DIG);
      busy <= 1'b1;
    end else begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  assign done = busy && (cnt == '0);

  // every multiplier digit consumed once the product is reported
  a_digits_used: assert property (@(posedge clk) disable iff (rst)
    done |-> ml_sh == '0)
    else $error("multiplier digits left at done");

  // no new product while one is still being built
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy || done)
    else $error("multiplier restarted while busy");

  // a started product is under way, busy and not yet done, once start is taken
  a_finish: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done)
    else $error("multiplier did not run after start");

endmodule

/* sv/sts_trace_mem.sv */
// Column value store: one write port, one registered read port.
module sts_trace_mem import sts_pkg::*; #(
  parameter  int DEPTH  = 960,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  sample_t           wr_data,
  input  logic              re,
  input  logic [ADDR_W-1:0] rd_addr,
  output sample_t           rd_data
);

  sample_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/scope_trace_smoother.sv */
// An item is taken only in the idle state, so a new item waits until the previous result
// is in the output register; the work per item is set by the four-step sample sum and two
// 5-digit passes of the shared 2-bit digit-serial multiplier, both skipped for an unseen channel.
// Reset (rst, synchronous): seen mask cleared, previous rows to centre, weight to 96,
// then a clearing pass over all CHANNELS*COLUMNS entries (960 by default) zeroes the store;
// no item is taken during that pass, weight writes are.
module scope_trace_smoother import sts_pkg::*; #(
  parameter int CHANNELS  = 32,
  parameter int COLUMNS   = 30,
  parameter int CELL_ROWS = 44
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [WEIGHT_W-1:0] cfg_wdata,
  sts_in_if.sink              item,
  sts_out_if.source           result
);

  localparam int DEPTH     = CHANNELS * COLUMNS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W     = $clog2(CELL_ROWS);
  localparam int CENTRE    = CELL_ROWS / 2;
  localparam int HALF_SPAN = CELL_ROWS / 2 - 1;
  localparam int RQ_W      = SAMPLE_W + 1;
  localparam int RAW_W     = SAMPLE_W + 2;
  localparam logic [CH_FW-1:0]  CH_MAX  = CH_FW'(CHANNELS - 1);
  localparam logic [COL_FW-1:0] COL_MAX = (COLUMNS > 2**COL_FW) ? {COL_FW{1'b1}}
                                                                : COL_FW'(COLUMNS - 1);

  state_t state, state_next;

  logic [WEIGHT_W-1:0] weight;
  logic [CHANNELS-1:0] seen;
  logic [ROW_W-1:0]    prev_row [CHANNELS];
  logic [ADDR_W-1:0]   clr_addr;

  // latched item
  logic [CH_FW-1:0]  ch_r;
  logic [COL_FW-1:0] col_r;
  logic              active_r;
  logic              muted_r;
  logic              soloed_r;
  logic              unseen_r;
  logic [ADDR_W-1:0] addr_r;

  // result register
  logic              res_valid;
  logic [CH_FW-1:0]  res_ch;
  logic [COL_FW-1:0] res_col;
  logic [ROW_FW-1:0] res_top;
  logic [ROW_FW-1:0] res_bot;
  colour_t           res_colour;

  logic [CH_FW-1:0]  ch_sat;
  logic [COL_FW-1:0] col_sat;
  logic [CH_W-1:0]   ch_in_idx;
  logic [CH_W-1:0]   ch_idx;
  logic              seen_now;
  logic              accept;
  logic              out_free;
  logic              load_row;

  sample_t                  samples [N_SAMPLES];
  logic                     sum_done;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_adj;
  sample_t                  avg;
  sample_t                  old;
  logic [WEIGHT_W-1:0]      w_sat;
  logic signed [MCAND_W-1:0] diff;

  logic                      mul_start;
  logic                      mul_done;
  logic signed [MCAND_W-1:0] mcand;
  logic [WEIGHT_W-1:0]       mplier;
  logic signed [PROD_W-1:0]  product;

  logic [MCAND_W-1:0]       nv_sum;
  sample_t                  nv;
  logic signed [RQ_W-1:0]   rq;
  logic signed [RAW_W-1:0]  raw;
  logic [ROW_W-1:0]         row;
  logic [ROW_W-1:0]         prev;
  logic [ROW_W-1:0]         top;
  logic [ROW_W-1:0]         bot;
  colour_t                  colour;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wr_addr;
  sample_t           mem_wr_data;
  logic              mem_re;

  // input saturation and seen lookup
  always_comb begin
    ch_sat    = (item.channel > CH_MAX) ? CH_MAX : item.channel;
    col_sat   = (item.column > COL_MAX) ? COL_MAX : item.column;
    ch_in_idx = CH_W'(ch_sat);
    seen_now  = seen[ch_in_idx] | item.active;
    ch_idx    = CH_W'(ch_r);
  end

  assign accept   = item.valid && item.ready;
  assign out_free = !res_valid || result.ready;

  // samples into the shift line
  always_comb begin
    samples[0] = item.sample_a;
    samples[1] = item.sample_b;
    samples[2] = item.sample_c;
    samples[3] = item.sample_d;
  end

  sts_sample_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .samples (samples),
    .done    (sum_done),
    .sum     (sum)
  );

  // average toward zero, blend difference against the stored value
  always_comb begin
    sum_adj = sum;
    if (sum[SUM_W-1]) begin
      sum_adj = sum + SUM_W'(3);
    end
    avg   = sum_adj[SUM_W-1:2];
    w_sat = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
    if (active_r) begin
      diff = MCAND_W'(avg) - MCAND_W'(old);
    end else begin
      diff = '0 - MCAND_W'(old);
    end
  end

  // first pass: difference times weight; second pass: new value times half span
  always_comb begin
    if (state == ST_BLEND) begin
      mcand  = MCAND_W'(nv);
      mplier = WEIGHT_W'(HALF_SPAN);
    end else begin
      mcand  = diff;
      mplier = w_sat;
    end
  end

  sts_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mcand),
    .mplier  (mplier),
    .done    (mul_done),
    .product (product)
  );

  // new stored value: old + floor(diff*w / 256)
  always_comb begin
    nv_sum = MCAND_W'(old) + product[MCAND_W+BLEND_SHIFT-1:BLEND_SHIFT];
    nv     = nv_sum[SAMPLE_W-1:0];
  end

  // row from the scaled value, clamped to the cell, and the span
  always_comb begin
    rq  = product[ROW_SHIFT+RQ_W-1:ROW_SHIFT];
    raw = RAW_W'(CENTRE) - RAW_W'(rq);
    if (raw[RAW_W-1]) begin
      row = '0;
    end else if (raw > RAW_W'(CELL_ROWS - 1)) begin
      row = ROW_W'(CELL_ROWS - 1);
    end else begin
      row = ROW_W'(raw);
    end
    prev = (col_r == '0) ? ROW_W'(CENTRE) : prev_row[ch_idx];
    top  = (prev < row) ? prev : row;
    bot  = (prev < row) ? row : prev;
    if (muted_r) begin
      colour = COLOUR_MUTED;
    end else if (soloed_r) begin
      colour = COLOUR_SOLO;
    end else begin
      colour = COLOUR_NORMAL;
    end
  end

  sts_trace_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .re      (mem_re),
    .rd_addr (addr_r),
    .rd_data (old)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item.valid) begin
          state_next = seen_now ? ST_SUM : ST_ROW;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          state_next = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (mul_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (mul_done) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    item.ready  = 1'b0;
    mem_we      = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = nv;
    mem_re      = 1'b0;
    mul_start   = 1'b0;
    load_row    = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      ST_IDLE: begin
        item.ready = 1'b1;
      end
      ST_SUM: begin
        mem_re    = 1'b1;
        mul_start = sum_done;
      end
      ST_BLEND: begin
        mem_we    = mul_done;
        mul_start = mul_done;
      end
      ST_SCALE: begin
      end
      ST_ROW: begin
        load_row = out_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      seen     <= '0;
      weight   <= WEIGHT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        prev_row[i] <= ROW_W'(CENTRE);
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        weight <= cfg_wdata;
      end
      if (accept && item.active) begin
        seen[ch_in_idx] <= 1'b1;
      end
      if (load_row && !unseen_r) begin
        prev_row[ch_idx] <= row;
      end
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r     <= ch_sat;
      col_r    <= col_sat;
      active_r <= item.active;
      muted_r  <= item.muted;
      soloed_r <= item.soloed;
      unseen_r <= !seen_now;
      addr_r   <= ADDR_W'(ch_sat * COLUMNS + col_sat);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_row) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_row) begin
      res_ch  <= ch_r;
      res_col <= col_r;
      if (unseen_r) begin
        res_top    <= '0;
        res_bot    <= ROW_FW'(CELL_ROWS - 1);
        res_colour <= COLOUR_UNUSED;
      end else begin
        res_top    <= ROW_FW'(top);
        res_bot    <= ROW_FW'(bot);
        res_colour <= colour;
      end
    end
  end

  assign result.valid       = res_valid;
  assign result.out_channel = res_ch;
  assign result.out_column  = res_col;
  assign result.span_top    = res_top;
  assign result.span_bottom = res_bot;
  assign result.colour      = res_colour;

  // a channel once seen stays seen
  a_seen_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (seen & $past(seen)) == $past(seen))
    else $error("seen mask lost a channel");

  // finished result waits while the output register is still occupied
  a_row_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROW && res_valid && !result.ready |=> state == ST_ROW && $stable(res_top))
    else $error("result overwritten before transfer");

  // spans are ordered top to bottom
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && (ROW_W <= ROW_FW) |-> result.span_top <= result.span_bottom)
    else $error("span top below span bottom");

  // unused colour always comes with the fill starting at row zero
  a_unused_fill: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.colour == COLOUR_UNUSED |-> result.span_top == '0)
    else $error("unused colour without full fill");

endmodule

/* dv/scope_trace_smoother_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the scope trace smoother: directed table, then random sweeps.
module scope_trace_smoother_test;
  import sts_pkg::*;

  localparam int CHANNELS     = 32;
  localparam int COLUMNS      = 30;
  localparam int CELL_ROWS    = 44;
  localparam int CENTRE_ROW   = CELL_ROWS / 2;
  localparam int HALF_SPAN    = CELL_ROWS / 2 - 1;
  localparam int FULL_SCALE   = 1 << BLEND_SHIFT;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_ITEMS   = 200;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / NUM_PHASES;
  localparam int NUM_PLAN     = 23;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int KEEP_WEIGHT   = -1;

  // One column request as the sender drives it
  typedef struct packed {
    logic [CH_FW-1:0]  channel;
    logic [COL_FW-1:0] column;
    logic              active;
    logic              muted;
    logic              soloed;
    sample_t           sample_a;
    sample_t           sample_b;
    sample_t           sample_c;
    sample_t           sample_d;
  } column_item_t;

  // One drawn span as the block reports it
  typedef struct packed {
    logic [CH_FW-1:0]  channel;
    logic [COL_FW-1:0] column;
    logic [ROW_FW-1:0] top;
    logic [ROW_FW-1:0] bottom;
    colour_t           colour;
  } span_t;

  // Directed step: optional weight write, the column, and an optional hand-typed span
  typedef struct packed {
    int           weight;
    column_item_t item;
    bit           typed;
    span_t        want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [WEIGHT_W-1:0] cfg_wdata;

  sts_in_if  items_bus ();
  sts_out_if spans_bus ();

  scope_trace_smoother #(
    .CHANNELS (CHANNELS),
    .COLUMNS  (COLUMNS),
    .CELL_ROWS(CELL_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (items_bus),
    .result   (spans_bus)
  );

  // Shadow of the block's state for span prediction
  logic signed [SAMPLE_W-1:0] trace_level [CHANNELS][COLUMNS];
  logic [CHANNELS-1:0]        seen_channels;
  logic [ROW_FW-1:0]          last_row [CHANNELS];
  logic [WEIGHT_W-1:0]        blend_weight;

  span_t     expected_spans [$];
  plan_row_t plan [NUM_PLAN];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_quiet = 0;
  bit        wind_down = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Blend one column into the shadow store and work out the span it draws
  function automatic span_t predict_span(column_item_t it);
    int    ch;
    int    col;
    int    w;
    int    avg;
    int    prior;
    int    level;
    int    row;
    int    prev;
    span_t s;
    ch  = (it.channel >= CHANNELS) ? CHANNELS - 1 : int'(it.channel);
    col = (it.column >= COLUMNS) ? COLUMNS - 1 : int'(it.column);
    w   = (blend_weight > WEIGHT_FULL) ? FULL_SCALE : int'(blend_weight);
    if (it.active) seen_channels[ch] = 1'b1;
    s.channel = ch[CH_FW-1:0];
    s.column  = col[COL_FW-1:0];
    // never-seen channel idles on the gray fill
    if (!seen_channels[ch]) begin
      s.top    = '0;
      s.bottom = ROW_FW'(CELL_ROWS - 1);
      s.colour = COLOUR_UNUSED;
      return s;
    end
    prior = int'(trace_level[ch][col]);
    if (it.active) begin
      // division truncates toward zero, the blend shift floors
      avg = (int'($signed(it.sample_a)) + int'($signed(it.sample_b)) +
             int'($signed(it.sample_c)) + int'($signed(it.sample_d))) / N_SAMPLES;
      level = (avg * w + prior * (FULL_SCALE - w)) >>> BLEND_SHIFT;
    end else begin
      level = (prior * (FULL_SCALE - w)) >>> BLEND_SHIFT;
    end
    trace_level[ch][col] = level[SAMPLE_W-1:0];
    row = CENTRE_ROW - ((level * HALF_SPAN) >>> ROW_SHIFT);
    if (row < 0) row = 0;
    if (row > CELL_ROWS - 1) row = CELL_ROWS - 1;
    prev = (col == 0) ? CENTRE_ROW : int'(last_row[ch]);
    s.top    = ROW_FW'((prev < row) ? prev : row);
    s.bottom = ROW_FW'((prev < row) ? row : prev);
    last_row[ch] = row[ROW_FW-1:0];
    s.colour = it.muted ? COLOUR_MUTED : (it.soloed ? COLOUR_SOLO : COLOUR_NORMAL);
    return s;
  endfunction

  function automatic plan_row_t plan_row(int wt, int ch, int col, bit act, bit mute,
                                         bit solo, int a, int b, int c, int d);
    plan_row_t r;
    r.weight         = wt;
    r.item.channel   = ch[CH_FW-1:0];
    r.item.column    = col[COL_FW-1:0];
    r.item.active    = act;
    r.item.muted     = mute;
    r.item.soloed    = solo;
    r.item.sample_a  = sample_t'(a);
    r.item.sample_b  = sample_t'(b);
    r.item.sample_c  = sample_t'(c);
    r.item.sample_d  = sample_t'(d);
    r.typed          = 1'b0;
    r.want           = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(plan_row_t r, int ch, int col, int top, int bottom,
                                          colour_t colour);
    r.typed          = 1'b1;
    r.want.channel   = ch[CH_FW-1:0];
    r.want.column    = col[COL_FW-1:0];
    r.want.top       = top[ROW_FW-1:0];
    r.want.bottom    = bottom[ROW_FW-1:0];
    r.want.colour    = colour;
    return r;
  endfunction

  // Drive one column and hold it until the transfer; called at a falling edge
  task automatic send_column(column_item_t it, bit typed, span_t want);
    span_t predicted;
    if (!wind_down) begin
      if (send_quiet > 0) begin
        send_quiet--;
      end else if ($urandom_range(0, 3) == 0) begin
        items_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else if ($urandom_range(0, 30) == 0) begin
        send_quiet = $urandom_range(20, 100);
      end
    end
    items_bus.channel  <= it.channel;
    items_bus.column   <= it.column;
    items_bus.active   <= it.active;
    items_bus.muted    <= it.muted;
    items_bus.soloed   <= it.soloed;
    items_bus.sample_a <= it.sample_a;
    items_bus.sample_b <= it.sample_b;
    items_bus.sample_c <= it.sample_c;
    items_bus.sample_d <= it.sample_d;
    items_bus.valid    <= 1'b1;
    do @(posedge clk); while (items_bus.ready !== 1'b1);
    predicted = predict_span(it);
    expected_spans.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Weight write with the block drained and idle; called at a falling edge
  task automatic set_weight(logic [WEIGHT_W-1:0] w);
    items_bus.valid <= 1'b0;
    while (expected_spans.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    blend_weight = w;
  endtask

  // Span receiver: stall bursts and stretches of steady acceptance
  initial begin
    int stall;
    int steady;
    stall  = 0;
    steady = 0;
    spans_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        spans_bus.ready <= 1'b0;
        stall--;
      end else if (!wind_down && steady == 0 && $urandom_range(0, 5) == 0) begin
        spans_bus.ready <= 1'b0;
        stall = $urandom_range(1, 11) - 1;
      end else begin
        spans_bus.ready <= 1'b1;
        if (steady > 0) steady--;
        else if ($urandom_range(0, 40) == 0) steady = $urandom_range(30, 150);
      end
    end
  end

  // Span checker against the oldest expectation
  always @(posedge clk) begin
    span_t want;
    if (!rst && spans_bus.valid === 1'b1 && spans_bus.ready === 1'b1) begin
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected span: ch %0d col %0d rows %0d..%0d colour %0d",
                   spans_bus.out_channel, spans_bus.out_column, spans_bus.span_top,
                   spans_bus.span_bottom, spans_bus.colour);
      end else begin
        want = expected_spans.pop_front();
        if (spans_bus.out_channel !== want.channel || spans_bus.out_column !== want.column ||
            spans_bus.span_top !== want.top || spans_bus.span_bottom !== want.bottom ||
            spans_bus.colour !== want.colour) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("span mismatch: expected ch %0d col %0d rows %0d..%0d colour %0d, %s",
                     want.channel, want.column, want.top, want.bottom, want.colour,
                     $sformatf("got ch %0d col %0d rows %0d..%0d colour %0d",
                               spans_bus.out_channel, spans_bus.out_column,
                               spans_bus.span_top, spans_bus.span_bottom, spans_bus.colour));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int           phase_weights [NUM_PHASES];
    column_item_t it;
    sample_t      s4 [N_SAMPLES];
    int           random_sent;
    int           phase;
    int           batch_len;
    int           ch;
    int           mode;
    int           base;
    bit           sweep;
    bit           quiet;
    bit           mute;
    bit           solo;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    items_bus.valid    = 1'b0;
    items_bus.channel  = '0;
    items_bus.column   = '0;
    items_bus.active   = 1'b0;
    items_bus.muted    = 1'b0;
    items_bus.soloed   = 1'b0;
    items_bus.sample_a = '0;
    items_bus.sample_b = '0;
    items_bus.sample_c = '0;
    items_bus.sample_d = '0;

    for (int c = 0; c < CHANNELS; c++) begin
      last_row[c] = ROW_FW'(CENTRE_ROW);
      for (int k = 0; k < COLUMNS; k++) trace_level[c][k] = '0;
    end
    seen_channels = '0;
    blend_weight  = WEIGHT_RESET;

    // Directed table; weight -1 keeps the current weight
    plan[0]  = typed_row(plan_row(KEEP_WEIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         0, 0, 0, CELL_ROWS - 1, COLOUR_UNUSED);
    plan[1]  = typed_row(plan_row(KEEP_WEIGHT, 31, 31, 0, 1, 0, 127, 127, 127, 127),
                         31, COLUMNS - 1, 0, CELL_ROWS - 1, COLOUR_UNUSED);
    plan[2]  = typed_row(plan_row(KEEP_WEIGHT, 5, 30, 0, 0, 1, -128, -128, -128, -128),
                         5, COLUMNS - 1, 0, CELL_ROWS - 1, COLOUR_UNUSED);
    plan[3]  = typed_row(plan_row(KEEP_WEIGHT, 6, 0, 1, 0, 0, 127, 127, 127, 127),
                         6, 0, 15, CENTRE_ROW, COLOUR_NORMAL);
    plan[4]  = typed_row(plan_row(0, 0, 0, 1, 0, 0, 127, 127, 127, 127),
                         0, 0, CENTRE_ROW, CENTRE_ROW, COLOUR_NORMAL);
    plan[5]  = typed_row(plan_row(KEEP_WEIGHT, 0, 1, 1, 0, 0, -128, -128, -128, -128),
                         0, 1, CENTRE_ROW, CENTRE_ROW, COLOUR_NORMAL);
    plan[6]  = plan_row(256, 0, 2, 1, 0, 0, 127, 127, 127, 127);
    plan[7]  = plan_row(KEEP_WEIGHT, 0, 3, 1, 0, 0, -128, -128, -128, -128);
    // negative sums that truncate toward zero
    plan[8]  = plan_row(KEEP_WEIGHT, 0, 4, 1, 0, 0, 127, -128, 127, -128);
    plan[9]  = plan_row(KEEP_WEIGHT, 0, 5, 1, 0, 0, -1, -1, -1, 0);
    // weight above full scale saturates
    plan[10] = plan_row(511, 1, 0, 1, 1, 1, 100, 100, 100, 100);
    plan[11] = plan_row(KEEP_WEIGHT, 1, 1, 1, 0, 1, -85, -86, -86, -86);
    // decay on a seen channel
    plan[12] = plan_row(96, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    plan[13] = plan_row(KEEP_WEIGHT, 1, 29, 0, 1, 0, 55, -55, 12, -12);
    plan[14] = plan_row(KEEP_WEIGHT, 0, 2, 0, 0, 0, 0, 0, 0, 0);
    plan[15] = plan_row(KEEP_WEIGHT, 0, 3, 0, 0, 1, 0, 0, 0, 0);
    plan[16] = plan_row(257, 2, 31, 1, 0, 0, -128, 127, -128, 127);
    plan[17] = plan_row(KEEP_WEIGHT, 2, 0, 1, 1, 1, 127, 127, 127, 127);
    plan[18] = plan_row(128, 31, 29, 1, 0, 0, 64, -64, 33, -7);
    plan[19] = plan_row(KEEP_WEIGHT, 31, 0, 0, 0, 0, -1, -1, -1, -1);
    plan[20] = plan_row(1, 3, 10, 1, 0, 0, 127, 127, 127, 127);
    plan[21] = plan_row(255, 3, 11, 1, 0, 0, -128, -128, -128, -128);
    plan[22] = plan_row(KEEP_WEIGHT, 30, 31, 1, 1, 0, 1, 2, 3, -7);

    phase_weights = '{96, 0, 256, 511, -1, 1, 255, -1};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    for (int i = 0; i < NUM_PLAN; i++) begin
      if (plan[i].weight != KEEP_WEIGHT) set_weight(plan[i].weight[WEIGHT_W-1:0]);
      send_column(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Random part: mostly full trace sweeps, some scattered noise columns
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase < NUM_PHASES && random_sent >= phase * PHASE_ITEMS) begin
        set_weight(phase_weights[phase] < 0 ? WEIGHT_W'($urandom_range(0, 511))
                                            : WEIGHT_W'(phase_weights[phase]));
        phase++;
      end
      wind_down = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
      sweep     = ($urandom_range(0, 9) < 7);
      batch_len = sweep ? COLUMNS : $urandom_range(1, 6);
      ch        = $urandom_range(0, CHANNELS - 1);
      mode      = sweep ? $urandom_range(0, 2) : 0;
      base      = $urandom_range(0, 255);
      quiet     = ($urandom_range(0, 4) == 0);
      mute      = ($urandom_range(0, 3) == 0);
      solo      = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < batch_len; k++) begin
        if (sweep) begin
          it.channel = ch[CH_FW-1:0];
          it.column  = k[COL_FW-1:0];
          it.active  = !quiet && ($urandom_range(0, 7) != 0);
          it.muted   = mute;
          it.soloed  = solo;
        end else begin
          it.channel = CH_FW'($urandom_range(0, 31));
          it.column  = COL_FW'($urandom_range(0, 31));
          it.active  = 1'($urandom_range(0, 1));
          it.muted   = 1'($urandom_range(0, 1));
          it.soloed  = 1'($urandom_range(0, 1));
        end
        // full-range noise, a jittered level, or rail-to-rail swings
        for (int n = 0; n < N_SAMPLES; n++) begin
          case (mode)
            0: s4[n] = sample_t'($urandom_range(0, 255));
            1: s4[n] = sample_t'(base + int'($urandom_range(0, 6)) - 3);
            default: s4[n] = ($urandom_range(0, 1) == 1) ? sample_t'(127) : sample_t'(-128);
          endcase
        end
        it.sample_a = s4[0];
        it.sample_b = s4[1];
        it.sample_c = s4[2];
        it.sample_d = s4[3];
        send_column(it, 1'b0, '0);
        random_sent++;
      end
    end

    // Drain and let the block settle
    items_bus.valid <= 1'b0;
    while (expected_spans.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
sv/sts_pkg.sv
sv/sts_in_if.sv
sv/sts_out_if.sv
sv/sts_sample_acc.sv
sv/sts_serial_mul.sv
sv/sts_trace_mem.sv
sv/scope_trace_smoother.sv
dv/scope_trace_smoother_test.sv
